// ===== rtl/sttd_pkg.sv =====
// Shared types and constants for the seconds-to-date-time converter.
package sttd_pkg;

    // Field widths
    localparam int SEC_IN_W = 38;
    localparam int TOTAL_W  = 39;
    localparam int DAYS_W   = 23;
    localparam int TOD_W    = 17;
    localparam int YEAR_W   = 15;
    localparam int MONTH_W  = 4;
    localparam int MDAY_W   = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int YDAY_W   = 9;

    // Calendar constants
    localparam int DAYS_400Y = 146097;
    localparam int DAYS_100Y = 36524;
    localparam int DAYS_4Y   = 1461;
    localparam int DAYS_1Y   = 365;
    localparam int YEARS_400 = 400;
    localparam int YEARS_100 = 100;
    localparam int SECS_HOUR = 3600;
    localparam int SECS_MIN  = 60;

    // Seconds per day is 2^7 * 675: shift off 7 bits, then divide by 675
    localparam int DAY_SHIFT = 7;
    localparam int DAY_ODD   = 675;
    localparam int DAY_K     = 41;
    localparam logic [31:0] DAY_RECIP = 32'((64'd1 << DAY_K) / 64'd675);

    // Floor reciprocal for the 400-year split, corrected afterwards
    localparam int Y400_K = 40;
    localparam logic [22:0] Y400_RECIP = 23'((64'd1 << Y400_K) / 64'd146097);

    // Exact ceiling reciprocals for narrow quotients
    localparam int C100_K = 29;
    localparam logic [15:0] C100_RECIP = 16'(((64'd1 << C100_K) + 64'd9130) / 64'd9131);
    localparam int C4_K = 27;
    localparam logic [16:0] C4_RECIP = 17'(((64'd1 << C4_K) + 64'd1460) / 64'd1461);
    localparam int C1_K = 21;
    localparam logic [12:0] C1_RECIP = 13'(((64'd1 << C1_K) + 64'd364) / 64'd365);
    localparam int HOUR_K = 20;
    localparam logic [12:0] HOUR_RECIP = 13'(((64'd1 << HOUR_K) + 64'd224) / 64'd225);
    localparam int MIN_K = 14;
    localparam logic [10:0] MIN_RECIP = 11'(((64'd1 << MIN_K) + 64'd14) / 64'd15);

    // Cumulative days before each month of a common year, index 0 is zero
    localparam logic [12:0][8:0] CUM_DAYS = {
        9'd365, 9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
        9'd151, 9'd120, 9'd90, 9'd59, 9'd31, 9'd0
    };

    // Pipeline depths
    localparam int SP_STAGES = 4;
    localparam int YR_STAGES = 9;
    localparam int MO_STAGES = 2;

    // Whole days and time of day
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } t_day_tod;

    // Year, day of year and time of day
    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic              leap;
        logic [YDAY_W-1:0] yday;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_year_day;

    // Finished result
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  mday;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_date_time;

    // Working set of the day split stages
    typedef struct packed {
        logic [TOTAL_W-1:0] sum;
        logic [DAYS_W-1:0]  q;
        logic [10:0]        r;
        logic [DAYS_W-1:0]  days;
        logic [TOD_W-1:0]   tod;
    } t_sp_work;

    // Working set of the year stages
    typedef struct packed {
        logic [DAYS_W-1:0] d;
        logic [5:0]        q;
        logic [18:0]       r;
        logic [5:0]        n400;
        logic [17:0]       d1;
        logic [2:0]        n100;
        logic [15:0]       d2;
        logic [4:0]        n4;
        logic [10:0]       d3;
        logic [2:0]        n1;
        logic [YEAR_W-1:0] yacc;
        logic [YEAR_W-1:0] year;
        logic              leap;
        logic [YDAY_W-1:0] yday;
        logic [TOD_W-1:0]  tod;
        logic [11:0]       trem;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_yr_work;

    // Working set of the month stages
    typedef struct packed {
        t_year_day          yd;
        logic [MONTH_W-1:0] month;
        logic [YDAY_W-1:0]  days_prior;
        logic [MDAY_W-1:0]  mday;
    } t_mo_work;

endpackage

// ===== rtl/sttd_day_split.sv =====
// Pipeline stages that add the epoch and split total seconds into days and time of day.
module sttd_day_split (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sttd_pkg::SEC_IN_W-1:0] i_elapsed,
    input  logic [sttd_pkg::SEC_IN_W-1:0] i_epoch,
    output logic                          o_valid,
    input  logic                          i_ready,
    output sttd_pkg::t_day_tod            o_item
);

    logic [sttd_pkg::SP_STAGES-1:0] r_v;
    logic [sttd_pkg::SP_STAGES-1:0] w_go;
    sttd_pkg::t_sp_work             r_s [sttd_pkg::SP_STAGES];
    sttd_pkg::t_sp_work             n_s [sttd_pkg::SP_STAGES];
    logic [63:0]                    w_prod;
    logic [31:0]                    w_qm;
    logic [31:0]                    w_x1;
    logic [31:0]                    w_x2;

    // A stage advances when it is empty or the next one advances
    always_comb begin
        w_go[sttd_pkg::SP_STAGES-1] = !r_v[sttd_pkg::SP_STAGES-1] || i_ready;
        for (int k = sttd_pkg::SP_STAGES - 2; k >= 0; k--) begin
            w_go[k] = !r_v[k] || w_go[k+1];
        end
    end

    assign w_x1   = r_s[0].sum[sttd_pkg::TOTAL_W-1:sttd_pkg::DAY_SHIFT];
    assign w_x2   = r_s[1].sum[sttd_pkg::TOTAL_W-1:sttd_pkg::DAY_SHIFT];
    assign w_prod = 64'(w_x1) * 64'(sttd_pkg::DAY_RECIP);
    assign w_qm   = 32'(r_s[1].q) * 32'(sttd_pkg::DAY_ODD);

    // Stage work
    always_comb begin
        // Form the total
        n_s[0]     = '0;
        n_s[0].sum = sttd_pkg::TOTAL_W'(i_elapsed) + sttd_pkg::TOTAL_W'(i_epoch);
        // Estimate the day count from the reciprocal
        n_s[1]   = r_s[0];
        n_s[1].q = w_prod[63:sttd_pkg::DAY_K];
        // Remainder of the estimate, below twice the divisor
        n_s[2]   = r_s[1];
        n_s[2].r = 11'(w_x2 - w_qm);
        // Correct the estimate by one where needed
        n_s[3] = r_s[2];
        if (r_s[2].r >= 11'(sttd_pkg::DAY_ODD)) begin
            n_s[3].days = r_s[2].q + 1'b1;
            n_s[3].tod  = {10'(r_s[2].r - 11'(sttd_pkg::DAY_ODD)),
                           r_s[2].sum[sttd_pkg::DAY_SHIFT-1:0]};
        end else begin
            n_s[3].days = r_s[2].q;
            n_s[3].tod  = {r_s[2].r[9:0], r_s[2].sum[sttd_pkg::DAY_SHIFT-1:0]};
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_go[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < sttd_pkg::SP_STAGES; k++) begin
                if (w_go[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < sttd_pkg::SP_STAGES; k++) begin
            if (w_go[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_ready     = w_go[0];
    assign o_valid     = r_v[sttd_pkg::SP_STAGES-1];
    assign o_item.days = r_s[sttd_pkg::SP_STAGES-1].days;
    assign o_item.tod  = r_s[sttd_pkg::SP_STAGES-1].tod;

endmodule

// ===== rtl/sttd_year.sv =====
// Pipeline stages that break the day count into year cycles and the time of day into fields.
module sttd_year (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sttd_pkg::t_day_tod  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output sttd_pkg::t_year_day o_item
);

    logic [sttd_pkg::YR_STAGES-1:0] r_v;
    logic [sttd_pkg::YR_STAGES-1:0] w_go;
    sttd_pkg::t_yr_work             r_s [sttd_pkg::YR_STAGES];
    sttd_pkg::t_yr_work             n_s [sttd_pkg::YR_STAGES];
    logic [45:0]                    w_p400;
    logic [24:0]                    w_ph;
    logic [19:0]                    w_pm;
    logic [31:0]                    w_p100;
    logic [32:0]                    w_p4;
    logic [23:0]                    w_p1;

    // A stage advances when it is empty or the next one advances
    always_comb begin
        w_go[sttd_pkg::YR_STAGES-1] = !r_v[sttd_pkg::YR_STAGES-1] || i_ready;
        for (int k = sttd_pkg::YR_STAGES - 2; k >= 0; k--) begin
            w_go[k] = !r_v[k] || w_go[k+1];
        end
    end

    // Reciprocal products for the stages that divide
    assign w_p400 = 46'(i_item.days) * 46'(sttd_pkg::Y400_RECIP);
    assign w_ph   = 25'(i_item.tod[sttd_pkg::TOD_W-1:4]) * 25'(sttd_pkg::HOUR_RECIP);
    assign w_pm   = 20'(r_s[1].trem[11:2]) * 20'(sttd_pkg::MIN_RECIP);
    assign w_p100 = 32'(r_s[2].d1[17:2]) * 32'(sttd_pkg::C100_RECIP);
    assign w_p4   = 33'(r_s[4].d2) * 33'(sttd_pkg::C4_RECIP);
    assign w_p1   = 24'(r_s[6].d3) * 24'(sttd_pkg::C1_RECIP);

    // Stage work
    always_comb begin
        // Estimate 400-year count, hour
        n_s[0]      = '0;
        n_s[0].d    = i_item.days;
        n_s[0].tod  = i_item.tod;
        n_s[0].q    = w_p400[45:sttd_pkg::Y400_K];
        n_s[0].hour = w_ph[24:sttd_pkg::HOUR_K];

        // Remainders of the 400-year estimate and of the hour
        n_s[1]      = r_s[0];
        n_s[1].r    = 19'(r_s[0].d - 23'(23'(r_s[0].q) * 23'(sttd_pkg::DAYS_400Y)));
        n_s[1].trem = 12'(r_s[0].tod - 17'(17'(r_s[0].hour) * 17'(sttd_pkg::SECS_HOUR)));

        // Correct the 400-year count, minute
        n_s[2] = r_s[1];
        if (r_s[1].r >= 19'(sttd_pkg::DAYS_400Y)) begin
            n_s[2].n400 = r_s[1].q + 1'b1;
            n_s[2].d1   = 18'(r_s[1].r - 19'(sttd_pkg::DAYS_400Y));
        end else begin
            n_s[2].n400 = r_s[1].q;
            n_s[2].d1   = r_s[1].r[17:0];
        end
        n_s[2].minute = w_pm[19:sttd_pkg::MIN_K];

        // Century count before the clamp, second
        n_s[3]        = r_s[2];
        n_s[3].n100   = w_p100[31:sttd_pkg::C100_K];
        n_s[3].second = 6'(r_s[2].trem - 12'(12'(r_s[2].minute) * 12'(sttd_pkg::SECS_MIN)));

        // Clamp the century count at the end of a 400-year cycle
        n_s[4] = r_s[3];
        if (r_s[3].n100 > 3'd3) begin
            n_s[4].n100 = 3'd3;
        end
        n_s[4].d2   = 16'(r_s[3].d1 - 18'(18'(n_s[4].n100) * 18'(sttd_pkg::DAYS_100Y)));
        n_s[4].yacc = 15'(15'(r_s[3].n400) * 15'(sttd_pkg::YEARS_400))
                    + 15'(15'(n_s[4].n100) * 15'(sttd_pkg::YEARS_100));

        // Four-year count
        n_s[5]    = r_s[4];
        n_s[5].n4 = w_p4[31:sttd_pkg::C4_K];

        // Days within the four-year cycle
        n_s[6]      = r_s[5];
        n_s[6].d3   = 11'(r_s[5].d2 - 16'(16'(r_s[5].n4) * 16'(sttd_pkg::DAYS_4Y)));
        n_s[6].yacc = r_s[5].yacc + 15'({r_s[5].n4, 2'b00});

        // Year count before the clamp
        n_s[7]    = r_s[6];
        n_s[7].n1 = w_p1[23:sttd_pkg::C1_K];

        // Clamp the year count at the end of a leap cycle, finish year and leap flag
        n_s[8] = r_s[7];
        if (r_s[7].n1 > 3'd3) begin
            n_s[8].n1 = 3'd3;
        end
        n_s[8].yday = 9'(r_s[7].d3 - 11'(11'(n_s[8].n1) * 11'(sttd_pkg::DAYS_1Y)) + 11'd1);
        n_s[8].year = r_s[7].yacc + 15'(n_s[8].n1) + 15'd1;
        n_s[8].leap = (n_s[8].n1 == 3'd3) && ((r_s[7].n4 != 5'd24) || (r_s[7].n100 == 3'd3));
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_go[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < sttd_pkg::YR_STAGES; k++) begin
                if (w_go[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < sttd_pkg::YR_STAGES; k++) begin
            if (w_go[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_ready       = w_go[0];
    assign o_valid       = r_v[sttd_pkg::YR_STAGES-1];
    assign o_item.year   = r_s[sttd_pkg::YR_STAGES-1].year;
    assign o_item.leap   = r_s[sttd_pkg::YR_STAGES-1].leap;
    assign o_item.yday   = r_s[sttd_pkg::YR_STAGES-1].yday;
    assign o_item.hour   = r_s[sttd_pkg::YR_STAGES-1].hour;
    assign o_item.minute = r_s[sttd_pkg::YR_STAGES-1].minute;
    assign o_item.second = r_s[sttd_pkg::YR_STAGES-1].second;

endmodule

// ===== rtl/sttd_month.sv =====
// Pipeline stages that map the day of the year to month and day of month.
module sttd_month (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sttd_pkg::t_year_day  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sttd_pkg::t_date_time o_item
);

    logic [sttd_pkg::MO_STAGES-1:0] r_v;
    logic [sttd_pkg::MO_STAGES-1:0] w_go;
    sttd_pkg::t_mo_work             r_s [sttd_pkg::MO_STAGES];
    sttd_pkg::t_mo_work             n_s [sttd_pkg::MO_STAGES];

    // A stage advances when it is empty or the next one advances
    always_comb begin
        w_go[sttd_pkg::MO_STAGES-1] = !r_v[sttd_pkg::MO_STAGES-1] || i_ready;
        for (int k = sttd_pkg::MO_STAGES - 2; k >= 0; k--) begin
            w_go[k] = !r_v[k] || w_go[k+1];
        end
    end

    // Find the first month whose cumulative limit covers the day
    always_comb begin
        logic [8:0] limit;
        logic [8:0] extra;
        extra             = {8'd0, i_item.leap};
        n_s[0]            = '0;
        n_s[0].yd         = i_item;
        n_s[0].month      = 4'd12;
        n_s[0].days_prior = i_item.yday - 9'd1;
        for (int m = 12; m >= 1; m--) begin
            limit = sttd_pkg::CUM_DAYS[4'(m)] + ((m > 1) ? extra : 9'd0);
            if (i_item.yday <= limit) begin
                n_s[0].month      = 4'(m);
                n_s[0].days_prior = sttd_pkg::CUM_DAYS[4'(m - 1)] + ((m > 2) ? extra : 9'd0);
            end
        end
    end

    // Day of month
    always_comb begin
        n_s[1]      = r_s[0];
        n_s[1].mday = 5'(r_s[0].yd.yday - r_s[0].days_prior);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_go[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < sttd_pkg::MO_STAGES; k++) begin
                if (w_go[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < sttd_pkg::MO_STAGES; k++) begin
            if (w_go[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_ready       = w_go[0];
    assign o_valid       = r_v[sttd_pkg::MO_STAGES-1];
    assign o_item.year   = r_s[sttd_pkg::MO_STAGES-1].yd.year;
    assign o_item.month  = r_s[sttd_pkg::MO_STAGES-1].month;
    assign o_item.mday   = r_s[sttd_pkg::MO_STAGES-1].mday;
    assign o_item.hour   = r_s[sttd_pkg::MO_STAGES-1].yd.hour;
    assign o_item.minute = r_s[sttd_pkg::MO_STAGES-1].yd.minute;
    assign o_item.second = r_s[sttd_pkg::MO_STAGES-1].yd.second;

endmodule

// ===== rtl/seconds_to_date_time_core.sv =====
// Top level of the seconds to Gregorian date and time converter.
//
// Input stream: each transfer on the s_axis side carries a 38-bit count of
// seconds since the epoch; each produces exactly one transfer on the m_axis
// side with year, month, day of month, hour, minute and second.
// The epoch, in seconds from 0001-01-01 00:00:00, is written on the cfg
// channel (always ready); the user must write it only while no conversion
// is in flight, since the block itself does not enforce this.
// The datapath is a 15-stage pipeline: day split (4), year cycles and time
// of day (9), month lookup (2). Throughput is one conversion per cycle
// while the receiver does not stall, set by the reciprocal multipliers
// that each take one stage.
// Every stage carries its own valid bit; a stage loads whenever it is empty
// or the stage after it moves, so when the receiver stalls the pipeline
// fills its bubbles and keeps taking input until all stages hold items,
// and nothing is dropped or repeated.
// A synchronous reset clears all valid bits and sets the epoch to zero.
module seconds_to_date_time_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [37:0] elapsed_seconds
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [14:0] year, [18:15] month,
                                          // [23:19] day_of_month, [28:24] hour,
                                          // [34:29] minute, [40:35] second
    // Epoch register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [37:0] i_cfg_data
);

    logic [sttd_pkg::SEC_IN_W-1:0] r_epoch;
    logic                          w_sp_valid;
    logic                          w_sp_ready;
    sttd_pkg::t_day_tod            w_sp_item;
    logic                          w_yr_valid;
    logic                          w_yr_ready;
    sttd_pkg::t_year_day           w_yr_item;
    sttd_pkg::t_date_time          w_out;

    // Hold the epoch offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= '0;
        end else if (i_cfg_valid) begin
            r_epoch <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    sttd_day_split u_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_elapsed (i_s_axis_tdata[sttd_pkg::SEC_IN_W-1:0]),
        .i_epoch   (r_epoch),
        .o_valid   (w_sp_valid),
        .i_ready   (w_sp_ready),
        .o_item    (w_sp_item)
    );

    sttd_year u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sp_valid),
        .o_ready (w_sp_ready),
        .i_item  (w_sp_item),
        .o_valid (w_yr_valid),
        .i_ready (w_yr_ready),
        .o_item  (w_yr_item)
    );

    sttd_month u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_yr_valid),
        .o_ready (w_yr_ready),
        .i_item  (w_yr_item),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_item  (w_out)
    );

    // Pack the result
    assign o_m_axis_tdata = {7'd0, w_out.second, w_out.minute, w_out.hour,
                             w_out.mday, w_out.month, w_out.year};

`ifndef SYNTH
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_out.month >= 4'd1) && (w_out.month <= 4'd12)
                            && (w_out.mday >= 5'd1) && (w_out.year >= 15'd1))
        else $error("converted date out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_out.hour <= 5'd23) && (w_out.minute <= 6'd59)
                            && (w_out.second <= 6'd59))
        else $error("converted time of day out of range");

    a_month_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_out.month == 4'd2) |-> (w_out.mday <= 5'd29))
        else $error("February day beyond 29");
`endif

endmodule
